/* design/mdmls_pkg.sv */
// Package for the multi-hart data memory: sizes, funct3 codes, RAM request type.
// Lane-enable, store-data and load-extension functions.
// Depends on nothing; used by every design file.
package mdmls_pkg;

	localparam int NUM_HARTS          = 4;
	localparam int LOG_WORDS_PER_HART = 12;

	localparam int HART_W      = 2;
	localparam int BYTE_ADDR_W = 14;
	localparam int CODE_W      = 3;
	localparam int WORD_W      = 32;
	localparam int LANES       = WORD_W / 8;

	localparam int HART_IDX_W = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;
	localparam int RAM_ADDR_W = HART_IDX_W + LOG_WORDS_PER_HART;
	localparam int RAM_DEPTH  = 1 << RAM_ADDR_W;

	localparam logic [CODE_W-1:0] LD_B  = 3'd0;
	localparam logic [CODE_W-1:0] LD_H  = 3'd1;
	localparam logic [CODE_W-1:0] LD_W  = 3'd2;
	localparam logic [CODE_W-1:0] LD_BU = 3'd4;
	localparam logic [CODE_W-1:0] LD_HU = 3'd5;

	localparam logic [1:0] ST_B    = 2'd0;
	localparam logic [1:0] ST_H    = 2'd1;
	localparam logic [1:0] ST_W    = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	typedef logic [WORD_W-1:0]     word_t;
	typedef logic [LANES-1:0]      lane_en_t;
	typedef logic [RAM_ADDR_W-1:0] ram_addr_t;

	typedef struct packed {
		logic      re;
		logic      we;
		lane_en_t  be;
		ram_addr_t addr;
		word_t     wdata;
	} ram_req_t;

	function automatic lane_en_t store_lanes(input logic [1:0] sz, input logic [1:0] lane);
		lane_en_t be;
		be = '0;
		unique case (sz)
			ST_B:    be = lane_en_t'(4'b0001 << lane);
			ST_H:    be = lane[1] ? lane_en_t'(4'b1100) : lane_en_t'(4'b0011);
			ST_W:    be = lane_en_t'(4'b1111);
			ST_NONE: be = '0;
			default: be = '0;
		endcase
		return be;
	endfunction

	function automatic word_t store_data(input logic [1:0] sz, input word_t val);
		word_t d;
		d = val;
		unique case (sz)
			ST_B:    d = {4{val[7:0]}};
			ST_H:    d = {2{val[15:0]}};
			ST_W:    d = val;
			ST_NONE: d = val;
			default: d = val;
		endcase
		return d;
	endfunction

	function automatic word_t load_extend(input logic [CODE_W-1:0] code,
		input logic [1:0] lane, input word_t w);
		logic [7:0]  b;
		logic [15:0] h;
		word_t       r;
		b = 8'(w >> {lane, 3'b000});
		h = 16'(w >> {lane[1], 4'b0000});
		r = '0;
		unique case (code)
			LD_B:    r = {{24{b[7]}}, b};
			LD_H:    r = {{16{h[15]}}, h};
			LD_W:    r = w;
			LD_BU:   r = {24'd0, b};
			LD_HU:   r = {16'd0, h};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* design/mdmls_if.sv */
// Valid/ready channel interfaces for the data memory request and response.
// Depends on mdmls_pkg for field widths.
interface mdmls_req_if;
	logic                                valid;
	logic                                ready;
	logic                                mode;
	logic [mdmls_pkg::HART_W-1:0]        hart;
	logic [mdmls_pkg::BYTE_ADDR_W-1:0]   byte_address;
	logic [mdmls_pkg::CODE_W-1:0]        size_code;
	logic [mdmls_pkg::WORD_W-1:0]        store_value;

	modport source(output valid, mode, hart, byte_address, size_code, store_value,
		input ready);
	modport sink(input valid, mode, hart, byte_address, size_code, store_value,
		output ready);
endinterface

interface mdmls_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [mdmls_pkg::WORD_W-1:0]  load_data;

	modport source(output valid, load_data, input ready);
	modport sink(input valid, load_data, output ready);
endinterface

/* design/mdmls_ram.sv */
// Single-port data RAM with lane write enables and registered read data.
// Depends on mdmls_pkg for the request type and sizes.
module mdmls_ram (
	input  logic                clk,
	input  mdmls_pkg::ram_req_t req,
	output mdmls_pkg::word_t    rdata
);

	logic [mdmls_pkg::WORD_W-1:0] mem [mdmls_pkg::RAM_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			for (int i = 0; i < mdmls_pkg::LANES; i++) begin
				if (req.be[i]) begin
					mem[req.addr][8*i +: 8] <= req.wdata[8*i +: 8];
				end
			end
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

/* design/multihart_data_memory_load_store.sv */
// Top level of the multi-hart data memory: request decode, load pipeline, response register.
// Depends on mdmls_pkg, mdmls_if and mdmls_ram.
//
//   channel  dir  handshake    payload
//   req      in   valid/ready  mode, hart, byte_address, size_code, store_value
//   rsp      out  valid/ready  load_data (one per load, none per store)
//
// One item per cycle while req.ready is high. A store writes the RAM at its accept edge
// through lane enables. A load reads the RAM at its accept edge into the load stage.
// Reset clears the pipeline valids only; RAM contents are undefined until written.
// A stalled response holds the load stage; req.ready drops only when both are full.
module multihart_data_memory_load_store (
	input logic      clk,
	input logic      arst_n,
	mdmls_req_if.sink   req,
	mdmls_rsp_if.source rsp
);

	logic                                  accept;
	logic                                  hart_ok;
	logic                                  advance;
	logic [mdmls_pkg::LOG_WORDS_PER_HART-1:0] widx;
	logic [mdmls_pkg::HART_IDX_W-1:0]      hidx;
	mdmls_pkg::ram_req_t                   ram_req;
	mdmls_pkg::word_t                      ram_rdata;

	logic                                  valid_s1;
	logic [mdmls_pkg::CODE_W-1:0]          code_s1;
	logic [1:0]                            lane_s1;
	logic                                  ok_s1;
	logic                                  rsp_valid_q;
	mdmls_pkg::word_t                      rsp_data_q;

	assign accept  = req.valid && req.ready;
	assign hart_ok = int'(req.hart) < mdmls_pkg::NUM_HARTS;
	assign widx    = mdmls_pkg::LOG_WORDS_PER_HART'(req.byte_address >> 2);
	assign hidx    = mdmls_pkg::HART_IDX_W'(req.hart);

	always_comb begin
		ram_req.re    = accept && !req.mode;
		ram_req.we    = accept && req.mode && hart_ok;
		ram_req.be    = mdmls_pkg::store_lanes(req.size_code[1:0], req.byte_address[1:0]);
		ram_req.addr  = {hidx, widx};
		ram_req.wdata = mdmls_pkg::store_data(req.size_code[1:0], req.store_value);
	end

	mdmls_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept && !req.mode) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !req.mode) begin
			code_s1 <= req.size_code;
			lane_s1 <= req.byte_address[1:0];
			ok_s1   <= hart_ok;
		end
		if (advance) begin
			rsp_data_q <= ok_s1 ? mdmls_pkg::load_extend(code_s1, lane_s1, ram_rdata) : '0;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.load_data = rsp_data_q;

endmodule

/* design/mdmls_checker.sv */
// Port-level checks for the multi-hart data memory, bound to the top level.
// Depends on mdmls_pkg for widths.
module mdmls_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          req_mode,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [mdmls_pkg::WORD_W-1:0]  rsp_load_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response item dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_load_data))
		else $error("response item changed while stalled");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request stalled without a stalled response");

	a_load_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !req_mode && !rsp_valid |=> ##1 rsp_valid)
		else $error("load item did not produce a response in time");

endmodule

bind multihart_data_memory_load_store mdmls_checker u_mdmls_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_mode      (req.mode),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_load_data (rsp.load_data)
);
